@@ rtl/olrq_pkg.sv @@
// shared types and defaults for the overwrite-last ring queue
// no dependencies; imported by every module of the block

package olrq_pkg;

    // default geometry
    localparam int DEPTH_DEF     = 16;
    localparam int DATA_BITS_DEF = 32;

    // port field widths
    localparam int OP_BITS   = 1;
    localparam int WORD_BITS = 32;

    // item operation codes
    typedef enum logic [OP_BITS-1:0] {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_op;

    // read status handed from pointer control to the output stage
    typedef struct packed {
        logic pend;   // a pop read returns data this cycle
        logic hit;    // the pop found a word
    } t_rd_stat;

endpackage

@@ rtl/olrq_mem.sv @@
// entry storage of the ring queue: one write port, one registered read port
// depends on olrq_pkg

module olrq_mem import olrq_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF,
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  logic [DATA_BITS-1:0] i_wdata,
    input  logic                 i_re,
    input  logic [AW-1:0]        i_raddr,
    output logic [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [DATA_BITS-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered output
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/olrq_ctrl.sv @@
// head, tail and consumed-flag control; issues memory accesses per item
// depends on olrq_pkg

module olrq_ctrl import olrq_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF,
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  t_op                  i_op,
    input  logic [WORD_BITS-1:0] i_push_data,
    output logic                 o_we,
    output logic [AW-1:0]        o_waddr,
    output logic [DATA_BITS-1:0] o_wdata,
    output logic                 o_re,
    output logic [AW-1:0]        o_raddr,
    output t_rd_stat             o_rd_stat
);

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic          r_consumed, n_consumed;
    t_rd_stat      r_rd_stat, n_rd_stat;

    logic [AW-1:0] tail_next;
    logic [AW-1:0] head_next;
    logic          queue_empty;

    // ring successors
    assign tail_next   = (r_tail == LAST_IDX) ? '0 : r_tail + AW'(1);
    assign head_next   = (r_head == LAST_IDX) ? '0 : r_head + AW'(1);
    assign queue_empty = (r_head == r_tail) && r_consumed;

    // pointer update and memory access per accepted item
    always_comb begin
        n_head         = r_head;
        n_tail         = r_tail;
        n_consumed     = r_consumed;
        n_rd_stat.pend = 1'b0;
        n_rd_stat.hit  = 1'b0;
        o_we           = 1'b0;
        o_re           = 1'b0;
        o_raddr        = r_head;
        o_wdata        = DATA_BITS'(i_push_data);
        if (i_accept) begin
            case (i_op)
                OP_PUSH: begin
                    if (!((tail_next == r_head) || r_consumed)) begin
                        n_tail = tail_next;
                    end
                    o_we       = 1'b1;
                    n_consumed = 1'b0;
                end
                OP_POP: begin
                    n_rd_stat.pend = 1'b1;
                    if (!queue_empty) begin
                        n_rd_stat.hit = 1'b1;
                        o_re          = 1'b1;
                        if (r_head == r_tail) begin
                            n_consumed = 1'b1;
                        end else begin
                            n_head = head_next;
                        end
                    end
                end
                default: begin
                    n_rd_stat.pend = 1'b0;
                end
            endcase
        end
    end

    assign o_waddr = n_tail;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_consumed <= 1'b1;
            r_rd_stat  <= '0;
        end else begin
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_consumed <= n_consumed;
            r_rd_stat  <= n_rd_stat;
        end
    end

    assign o_rd_stat = r_rd_stat;

endmodule

@@ rtl/overwrite_last_ring_queue_core.sv @@
// overwrite-last ring queue: push stores a word, pop returns the oldest word
// a pop result passes the memory read register and then the result register to the port
// one push per cycle while no result waits; after a pop, no new item is taken
// until the entry memory read is done and its word goes into the result register
// reset: synchronous active low; head and tail at slot 0, tail slot empty
// depends on olrq_pkg, olrq_ctrl, olrq_mem

module overwrite_last_ring_queue_core import olrq_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [WORD_BITS-1:0] s_axis_tdata,   // [31:0] push_data
    input  logic [OP_BITS-1:0]   s_axis_tuser,   // [0] operation
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [WORD_BITS-1:0] m_axis_tdata,   // [31:0] pop_data
    output logic                 m_axis_tuser    // [0] pop_valid
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                 accept;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [DATA_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;
    logic [DATA_BITS-1:0] mem_rdata;
    t_rd_stat             rd_stat;

    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_out_data;
    logic                 r_out_hit;

    // take an item when no read is in flight and the result slot frees up
    assign s_axis_tready = !rd_stat.pend && (!r_out_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    olrq_ctrl #(
        .DEPTH     (DEPTH),
        .DATA_BITS (DATA_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_op        (t_op'(s_axis_tuser)),
        .i_push_data (s_axis_tdata),
        .o_we        (mem_we),
        .o_waddr     (mem_waddr),
        .o_wdata     (mem_wdata),
        .o_re        (mem_re),
        .o_raddr     (mem_raddr),
        .o_rd_stat   (rd_stat)
    );

    olrq_mem #(
        .DEPTH     (DEPTH),
        .DATA_BITS (DATA_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rd_stat.pend) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, zero when the queue was empty
    always_ff @(posedge i_clk) begin
        if (rd_stat.pend) begin
            r_out_data <= rd_stat.hit ? WORD_BITS'(mem_rdata) : '0;
            r_out_hit  <= rd_stat.hit;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_hit;

endmodule
